// ===== rtl/mrp_pkg.sv =====
// shared constants, codes and controller/datapath interface types of the msp response parser
package mrp_pkg;

    localparam int PAYLOAD_BYTES_DEF = 36;
    localparam int NOISE_LIMIT_DEF   = 64;

    localparam int RESULT_CAP = 18;
    localparam int CNT_W      = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [1:0] MODE_START   = 2'd0;
    localparam logic [1:0] MODE_BYTE    = 2'd1;
    localparam logic [1:0] MODE_TIMEOUT = 2'd2;
    localparam logic [1:0] MODE_NONE    = 2'd3;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_TIMEOUT  = 3'd1;
    localparam logic [2:0] ST_FRAMING  = 3'd2;
    localparam logic [2:0] ST_CHECKSUM = 3'd3;
    localparam logic [2:0] ST_COMMAND  = 3'd4;
    localparam logic [2:0] ST_SHORT    = 3'd5;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_M      = 8'h4D;
    localparam logic [7:0] CH_GT     = 8'h3E;

    localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_COMMAND = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_CHANNELS     = 1'b1;

    localparam logic [7:0]       EXPECTED_COMMAND_RST = 8'd105;
    localparam logic [CNT_W-1:0] MAX_CHANNELS_RST     = 5'd18;

    typedef struct packed {
        logic       clr_noise;
        logic       inc_noise;
        logic       ld_size;
        logic       ld_cmd;
        logic       ld_data;
        logic       ld_count;
        logic       rd_issue;
        logic       adv_k;
        logic       out_load;
        logic       out_channel;
        logic [2:0] out_status;
    } mrp_cmd_t;

    typedef struct packed {
        logic is_dollar;
        logic is_m;
        logic is_gt;
        logic noise_full;
        logic size_zero;
        logic data_done;
        logic csum_bad;
        logic cmd_bad;
        logic too_short;
        logic count_zero;
        logic emit_last;
        logic out_free;
    } mrp_status_t;

endpackage

// ===== rtl/mrp_ctrl.sv =====
// frame state machine of the msp response parser
module mrp_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          mode,
    input  mrp_pkg::mrp_status_t sts,
    output mrp_pkg::mrp_cmd_t   cmd
);
    import mrp_pkg::*;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_HUNT    = 4'd1;
    localparam logic [3:0] S_M       = 4'd2;
    localparam logic [3:0] S_GT      = 4'd3;
    localparam logic [3:0] S_SIZE    = 4'd4;
    localparam logic [3:0] S_CMD     = 4'd5;
    localparam logic [3:0] S_DATA    = 4'd6;
    localparam logic [3:0] S_CSUM    = 4'd7;
    localparam logic [3:0] S_EMIT_RD = 4'd8;
    localparam logic [3:0] S_EMIT_WR = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       emitting;
    logic       in_acc;

    assign emitting = (state_reg == S_EMIT_RD) || (state_reg == S_EMIT_WR);
    assign in_stall = emitting || !sts.out_free;
    assign in_acc   = in_valid && !in_stall;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        if (in_acc)
        begin
            priority if (mode == MODE_START)
            begin
                cmd.clr_noise = 1'b1;
                state_next    = S_HUNT;
            end
            else if (mode == MODE_NONE || state_reg == S_IDLE)
            begin
                state_next = state_reg;
            end
            else if (mode == MODE_TIMEOUT)
            begin
                cmd.out_load   = 1'b1;
                cmd.out_status = ST_TIMEOUT;
                state_next     = S_IDLE;
            end
            else
            begin
                unique case (state_reg)
                    S_HUNT:
                    begin
                        if (sts.is_dollar)
                        begin
                            state_next = S_M;
                        end
                        else
                        begin
                            cmd.inc_noise = 1'b1;
                            if (sts.noise_full)
                            begin
                                cmd.out_load   = 1'b1;
                                cmd.out_status = ST_FRAMING;
                                state_next     = S_IDLE;
                            end
                        end
                    end
                    S_M:
                    begin
                        if (sts.is_m)
                        begin
                            state_next = S_GT;
                        end
                        else
                        begin
                            cmd.out_load   = 1'b1;
                            cmd.out_status = ST_FRAMING;
                            state_next     = S_IDLE;
                        end
                    end
                    S_GT:
                    begin
                        if (sts.is_gt)
                        begin
                            state_next = S_SIZE;
                        end
                        else
                        begin
                            cmd.out_load   = 1'b1;
                            cmd.out_status = ST_FRAMING;
                            state_next     = S_IDLE;
                        end
                    end
                    S_SIZE:
                    begin
                        cmd.ld_size = 1'b1;
                        state_next  = S_CMD;
                    end
                    S_CMD:
                    begin
                        cmd.ld_cmd = 1'b1;
                        state_next = sts.size_zero ? S_CSUM : S_DATA;
                    end
                    S_DATA:
                    begin
                        cmd.ld_data = 1'b1;
                        if (sts.data_done)
                        begin
                            state_next = S_CSUM;
                        end
                    end
                    S_CSUM:
                    begin
                        cmd.ld_count = 1'b1;
                        priority if (sts.csum_bad)
                        begin
                            cmd.out_load   = 1'b1;
                            cmd.out_status = ST_CHECKSUM;
                            state_next     = S_IDLE;
                        end
                        else if (sts.cmd_bad)
                        begin
                            cmd.out_load   = 1'b1;
                            cmd.out_status = ST_COMMAND;
                            state_next     = S_IDLE;
                        end
                        else if (sts.too_short)
                        begin
                            cmd.out_load   = 1'b1;
                            cmd.out_status = ST_SHORT;
                            state_next     = S_IDLE;
                        end
                        else if (sts.count_zero)
                        begin
                            cmd.out_load   = 1'b1;
                            cmd.out_status = ST_OK;
                            state_next     = S_IDLE;
                        end
                        else
                        begin
                            state_next = S_EMIT_RD;
                        end
                    end
                    default:
                    begin
                        state_next = state_reg;
                    end
                endcase
            end
        end
        else if (state_reg == S_EMIT_RD)
        begin
            cmd.rd_issue = 1'b1;
            state_next   = S_EMIT_WR;
        end
        else if (state_reg == S_EMIT_WR && sts.out_free)
        begin
            cmd.out_load    = 1'b1;
            cmd.out_channel = 1'b1;
            cmd.out_status  = ST_OK;
            cmd.adv_k       = 1'b1;
            state_next      = sts.emit_last ? S_IDLE : S_EMIT_RD;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/mrp_dp.sv =====
// datapath of the msp response parser: frame fields, payload banks, output register
module mrp_dp #(
    parameter int PAYLOAD_BYTES = mrp_pkg::PAYLOAD_BYTES_DEF,
    parameter int NOISE_LIMIT   = mrp_pkg::NOISE_LIMIT_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [7:0]                     rx_byte,
    input  logic                           cfg_we,
    input  logic [mrp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mrp_pkg::CFG_DATA_W-1:0] cfg_data,
    input  mrp_pkg::mrp_cmd_t              cmd,
    output mrp_pkg::mrp_status_t           sts,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [2:0]                     status,
    output logic [mrp_pkg::CNT_W-1:0]      channel_index,
    output logic [15:0]                    channel_value,
    output logic [mrp_pkg::CNT_W-1:0]      channel_count,
    output logic                           channel_valid,
    output logic                           last
);
    import mrp_pkg::*;

    localparam int BANK_DEPTH = (PAYLOAD_BYTES + 1) / 2;
    localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

    logic [7:0]       expected_command_reg;
    logic [CNT_W-1:0] max_channels_reg;
    logic [6:0]       noise_reg;
    logic [6:0]       noise_next;
    logic [7:0]       frame_size_reg;
    logic [7:0]       frame_command_reg;
    logic [7:0]       checksum_reg;
    logic [7:0]       byte_index_reg;
    logic [7:0]       byte_index_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] k_reg;
    logic [CNT_W-1:0] k_next;
    logic [7:0]       lo_rd_reg;
    logic [7:0]       hi_rd_reg;

    logic [7:0] even_mem [BANK_DEPTH];
    logic [7:0] odd_mem  [BANK_DEPTH];

    logic             out_valid_reg;
    logic [2:0]       status_reg;
    logic [CNT_W-1:0] index_reg;
    logic [15:0]      value_reg;
    logic [CNT_W-1:0] ocount_reg;
    logic             cvalid_reg;
    logic             last_reg;

    logic [7:0]       stored;
    logic [7:0]       half;
    logic [7:0]       cap_a;
    logic [7:0]       cnt_full;
    logic             wr_in_range;
    logic [BANK_AW-1:0] wr_addr;
    logic [BANK_AW-1:0] rd_addr;

    assign noise_next      = noise_reg + 7'd1;
    assign byte_index_next = byte_index_reg + 8'd1;
    assign k_next          = k_reg + 5'd1;

    // channel count from stored bytes, register limit and result cap
    always_comb
    begin
        stored   = (frame_size_reg > 8'(PAYLOAD_BYTES)) ? 8'(PAYLOAD_BYTES) : frame_size_reg;
        half     = stored >> 1;
        cap_a    = ({3'b000, max_channels_reg} < half) ? {3'b000, max_channels_reg} : half;
        cnt_full = (cap_a > 8'(RESULT_CAP)) ? 8'(RESULT_CAP) : cap_a;
    end

    always_comb
    begin
        sts.is_dollar  = (rx_byte == CH_DOLLAR);
        sts.is_m       = (rx_byte == CH_M);
        sts.is_gt      = (rx_byte == CH_GT);
        sts.noise_full = (noise_next >= 7'(NOISE_LIMIT));
        sts.size_zero  = (frame_size_reg == 8'd0);
        sts.data_done  = (byte_index_next == frame_size_reg);
        sts.csum_bad   = (rx_byte != checksum_reg);
        sts.cmd_bad    = (frame_command_reg != expected_command_reg);
        sts.too_short  = (frame_size_reg < 8'd2);
        sts.count_zero = (cnt_full == 8'd0);
        sts.emit_last  = (k_next == count_reg);
        sts.out_free   = !out_valid_reg || !out_stall;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_command_reg <= EXPECTED_COMMAND_RST;
            max_channels_reg     <= MAX_CHANNELS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_EXPECTED_COMMAND: expected_command_reg <= cfg_data;
                REG_MAX_CHANNELS:     max_channels_reg     <= cfg_data[CNT_W-1:0];
                default:              expected_command_reg <= expected_command_reg;
            endcase
        end
    end

    // frame field registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            noise_reg         <= '0;
            frame_size_reg    <= '0;
            frame_command_reg <= '0;
            checksum_reg      <= '0;
            byte_index_reg    <= '0;
            count_reg         <= '0;
            k_reg             <= '0;
        end
        else
        begin
            if (cmd.clr_noise)
            begin
                noise_reg <= '0;
            end
            else if (cmd.inc_noise)
            begin
                noise_reg <= noise_next;
            end
            if (cmd.ld_size)
            begin
                frame_size_reg <= rx_byte;
                checksum_reg   <= rx_byte;
            end
            if (cmd.ld_cmd)
            begin
                frame_command_reg <= rx_byte;
                checksum_reg      <= checksum_reg ^ rx_byte;
                byte_index_reg    <= '0;
            end
            if (cmd.ld_data)
            begin
                checksum_reg   <= checksum_reg ^ rx_byte;
                byte_index_reg <= byte_index_next;
            end
            if (cmd.ld_count)
            begin
                count_reg <= cnt_full[CNT_W-1:0];
                k_reg     <= '0;
            end
            else if (cmd.adv_k)
            begin
                k_reg <= k_next;
            end
        end
    end

    // payload banks, even and odd bytes side by side
    assign wr_in_range = (byte_index_reg < 8'(PAYLOAD_BYTES));
    assign wr_addr     = byte_index_reg[BANK_AW:1];
    assign rd_addr     = k_reg[BANK_AW-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.ld_data && wr_in_range)
        begin
            if (byte_index_reg[0])
            begin
                odd_mem[wr_addr] <= rx_byte;
            end
            else
            begin
                even_mem[wr_addr] <= rx_byte;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_issue)
        begin
            lo_rd_reg <= even_mem[rd_addr];
            hi_rd_reg <= odd_mem[rd_addr];
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            status_reg <= cmd.out_status;
            if (cmd.out_channel)
            begin
                index_reg  <= k_reg;
                value_reg  <= {hi_rd_reg, lo_rd_reg};
                ocount_reg <= count_reg;
                cvalid_reg <= 1'b1;
                last_reg   <= sts.emit_last;
            end
            else
            begin
                index_reg  <= '0;
                value_reg  <= '0;
                ocount_reg <= '0;
                cvalid_reg <= 1'b0;
                last_reg   <= 1'b1;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign channel_index = index_reg;
    assign channel_value = value_reg;
    assign channel_count = ocount_reg;
    assign channel_valid = cvalid_reg;
    assign last          = last_reg;

`ifndef ASSERT_OFF
    a_channel_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && cvalid_reg |-> status_reg == ST_OK)
        else $error("channel result with error status");
    a_error_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !cvalid_reg |-> last_reg)
        else $error("status-only result not flagged last");
    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && cvalid_reg |-> index_reg < ocount_reg)
        else $error("channel index beyond count");
    a_emit_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load && cmd.out_channel |-> count_reg != '0 && k_reg < count_reg)
        else $error("channel transfer with no channels left");
`endif

endmodule

// ===== rtl/msp_v1_rc_response_parser.sv =====
// top level of the msp v1 rc response parser
// Each input transfer is a start, a received byte, a byte timeout or none; start, byte and
// timeout events are taken one per cycle while the input is not stalled, and an input
// transfer is stalled only while the output register holds a result that is itself
// stalled or while a good response is being unloaded. A response that fails (timeout,
// framing, checksum, command, too short), or a good one with no channels, gives one
// status result; a good one gives its channels one by one, each read as a byte pair
// through the single read port of the payload banks and then loaded into the output
// register. Payload bytes are held in two byte-wide even/odd banks, not cleared by reset.
module msp_v1_rc_response_parser #(
    parameter int PAYLOAD_BYTES = mrp_pkg::PAYLOAD_BYTES_DEF,
    parameter int NOISE_LIMIT   = mrp_pkg::NOISE_LIMIT_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [1:0]                     mode,
    input  logic [7:0]                     rx_byte,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [2:0]                     status,
    output logic [mrp_pkg::CNT_W-1:0]      channel_index,
    output logic [15:0]                    channel_value,
    output logic [mrp_pkg::CNT_W-1:0]      channel_count,
    output logic                           channel_valid,
    output logic                           last,
    input  logic                           cfg_we,
    input  logic [mrp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mrp_pkg::CFG_DATA_W-1:0] cfg_data
);
    import mrp_pkg::*;

    mrp_cmd_t    cmd;
    mrp_status_t sts;

    mrp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .mode     (mode),
        .sts      (sts),
        .cmd      (cmd)
    );

    mrp_dp #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES),
        .NOISE_LIMIT   (NOISE_LIMIT)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .rx_byte       (rx_byte),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .cmd           (cmd),
        .sts           (sts),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .channel_index (channel_index),
        .channel_value (channel_value),
        .channel_count (channel_count),
        .channel_valid (channel_valid),
        .last          (last)
    );

endmodule

// ===== tb/sv/mrp_frame_checker.sv =====
`timescale 1ns / 1ps
// result checker of the msp response parser: predicts every response and compares its results
module mrp_frame_checker #(
    parameter int PAYLOAD_BYTES = mrp_pkg::PAYLOAD_BYTES_DEF,
    parameter int NOISE_LIMIT   = mrp_pkg::NOISE_LIMIT_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_stall,
    input  logic [1:0]                     mode,
    input  logic [7:0]                     rx_byte,
    input  logic                           out_valid,
    input  logic                           out_stall,
    input  logic [2:0]                     status,
    input  logic [mrp_pkg::CNT_W-1:0]      channel_index,
    input  logic [15:0]                    channel_value,
    input  logic [mrp_pkg::CNT_W-1:0]      channel_count,
    input  logic                           channel_valid,
    input  logic                           last,
    input  logic                           cfg_we,
    input  logic [mrp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mrp_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                             fail_count,
    output int                             pending
);
    import mrp_pkg::*;

    typedef enum logic [2:0] {
        P_IDLE, P_HUNT, P_M, P_GT, P_SIZE, P_CMD, P_DATA, P_CSUM
    } parse_phase_t;

    typedef struct packed {
        logic [2:0]       status;
        logic [CNT_W-1:0] index;
        logic [15:0]      value;
        logic [CNT_W-1:0] count;
        logic             ch_valid;
        logic             last;
    } rc_result_t;

    parse_phase_t     phase;
    logic [6:0]       noise_count;
    logic [7:0]       frame_size;
    logic [7:0]       frame_cmd;
    logic [7:0]       checksum;
    logic [7:0]       byte_idx;
    logic [7:0]       want_cmd;
    logic [CNT_W-1:0] max_ch;
    logic [7:0]       payload [PAYLOAD_BYTES];
    rc_result_t       predicted_results [$];

    function void post_result(logic [2:0] st, logic [CNT_W-1:0] idx, logic [15:0] val,
                              logic [CNT_W-1:0] cnt, logic ok, logic fin);
        rc_result_t r;
        r.status   = st;
        r.index    = idx;
        r.value    = val;
        r.count    = cnt;
        r.ch_valid = ok;
        r.last     = fin;
        predicted_results.push_back(r);
    endfunction

    function void abort_frame(logic [2:0] code);
        post_result(code, '0, '0, '0, 1'b0, 1'b1);
        phase = P_IDLE;
    endfunction

    function void close_frame(logic [7:0] b);
        int stored;
        int n;
        phase = P_IDLE;
        if (b != checksum)
            post_result(ST_CHECKSUM, '0, '0, '0, 1'b0, 1'b1);
        else if (frame_cmd != want_cmd)
            post_result(ST_COMMAND, '0, '0, '0, 1'b0, 1'b1);
        else
        begin
            stored = (frame_size > PAYLOAD_BYTES) ? PAYLOAD_BYTES : int'(frame_size);
            if (stored < 2)
                post_result(ST_SHORT, '0, '0, '0, 1'b0, 1'b1);
            else
            begin
                n = stored / 2;
                if (n > max_ch)
                    n = int'(max_ch);
                if (n > RESULT_CAP)
                    n = RESULT_CAP;
                if (n == 0)
                    post_result(ST_OK, '0, '0, '0, 1'b0, 1'b1);
                for (int k = 0; k < n; k++)
                    post_result(ST_OK, CNT_W'(k), {payload[2*k+1], payload[2*k]},
                                CNT_W'(n), 1'b1, k == n - 1);
            end
        end
    endfunction

    function void step_parser(logic [1:0] m, logic [7:0] b);
        if (m == MODE_START)
        begin
            phase = P_HUNT;
            noise_count = '0;
            return;
        end
        if (m == MODE_NONE || phase == P_IDLE)
            return;
        if (m == MODE_TIMEOUT)
        begin
            abort_frame(ST_TIMEOUT);
            return;
        end
        case (phase)
            P_HUNT:
            begin
                if (b == CH_DOLLAR)
                    phase = P_M;
                else
                begin
                    noise_count = noise_count + 7'd1;
                    if (noise_count >= NOISE_LIMIT)
                        abort_frame(ST_FRAMING);
                end
            end
            P_M:
            begin
                if (b != CH_M)
                    abort_frame(ST_FRAMING);
                else
                    phase = P_GT;
            end
            P_GT:
            begin
                if (b != CH_GT)
                    abort_frame(ST_FRAMING);
                else
                    phase = P_SIZE;
            end
            P_SIZE:
            begin
                frame_size = b;
                checksum = b;
                phase = P_CMD;
            end
            P_CMD:
            begin
                frame_cmd = b;
                checksum = checksum ^ b;
                byte_idx = '0;
                phase = (frame_size == 0) ? P_CSUM : P_DATA;
            end
            P_DATA:
            begin
                checksum = checksum ^ b;
                if (byte_idx < PAYLOAD_BYTES)
                    payload[byte_idx] = b;
                byte_idx = byte_idx + 8'd1;
                if (byte_idx == frame_size)
                    phase = P_CSUM;
            end
            default:
                close_frame(b);
        endcase
    endfunction

    function void check_field(string name, int want, int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    function void check_result();
        rc_result_t want;
        if (predicted_results.size() == 0)
        begin
            $error("result transfer with nothing predicted: status %0d index %0d value %0d",
                   status, channel_index, channel_value);
            fail_count++;
            return;
        end
        want = predicted_results.pop_front();
        check_field("status", int'(want.status), int'(status));
        check_field("channel_index", int'(want.index), int'(channel_index));
        check_field("channel_value", int'(want.value), int'(channel_value));
        check_field("channel_count", int'(want.count), int'(channel_count));
        check_field("channel_valid", int'(want.ch_valid), int'(channel_valid));
        check_field("last", int'(want.last), int'(last));
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase = P_IDLE;
            noise_count = '0;
            frame_size = '0;
            frame_cmd = '0;
            checksum = '0;
            byte_idx = '0;
            want_cmd = EXPECTED_COMMAND_RST;
            max_ch = MAX_CHANNELS_RST;
            fail_count = 0;
            predicted_results.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
                check_result();
            if (cfg_we)
            begin
                if (cfg_index == REG_EXPECTED_COMMAND)
                    want_cmd = cfg_data;
                else if (cfg_index == REG_MAX_CHANNELS)
                    max_ch = cfg_data[CNT_W-1:0];
            end
            if (in_valid && !in_stall)
                step_parser(mode, rx_byte);
        end
        pending = predicted_results.size();
    end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// top of the msp response parser testbench: clock, reset, stimulus and verdict
module testbench;
    import mrp_pkg::*;

    localparam int ITEMS         = 480;
    localparam int PHASES        = 6;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int STUCK_LIMIT   = 5000;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [1:0]            mode = MODE_NONE;
    logic [7:0]            rx_byte = 8'h00;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [2:0]            status;
    logic [CNT_W-1:0]      channel_index;
    logic [15:0]           channel_value;
    logic [CNT_W-1:0]      channel_count;
    logic                  channel_valid;
    logic                  last;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_EXPECTED_COMMAND;
    logic [CFG_DATA_W-1:0] cfg_data = 8'h00;

    int       fail_count;
    int       pending;
    int       items_sent = 0;
    bit       quiet = 1'b0;
    bit       hold_req = 1'b0;
    bit       hold_done = 1'b0;
    logic [7:0] want_cmd = EXPECTED_COMMAND_RST;
    logic [7:0] max_ch = 8'(MAX_CHANNELS_RST);

    msp_v1_rc_response_parser dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .mode          (mode),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .channel_index (channel_index),
        .channel_value (channel_value),
        .channel_count (channel_count),
        .channel_valid (channel_valid),
        .last          (last),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    mrp_frame_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .mode          (mode),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .channel_index (channel_index),
        .channel_value (channel_value),
        .channel_count (channel_count),
        .channel_valid (channel_valid),
        .last          (last),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    task send_item(input logic [1:0] m, input logic [7:0] b);
        if (!quiet && $urandom_range(0, 99) < 13)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        mode <= m;
        rx_byte <= b;
        do @(posedge clk); while (in_stall);
        items_sent++;
    endtask

    task send_preamble();
        send_item(MODE_BYTE, CH_DOLLAR);
        send_item(MODE_BYTE, CH_M);
        send_item(MODE_BYTE, CH_GT);
    endtask

    task write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // drain all outstanding results, then give the block time to go quiet
    task settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task send_noise();
        int n;
        n = $urandom_range(1, 5);
        repeat (n) send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
    endtask

    // one response frame; unless clean, may carry noise, a broken preamble, a wrong command,
    // a timeout inside the payload or a corrupted checksum
    task send_frame(input bit clean);
        int noise_n;
        int size;
        int flaw;
        int pick;
        logic [7:0] cmd;
        logic [7:0] sum;
        logic [7:0] b;
        flaw = clean ? 99 : $urandom_range(0, 99);
        pick = $urandom_range(0, 99);
        if (clean)
            size = PAYLOAD_BYTES_DEF;
        else if (pick < 75)
            size = $urandom_range(0, 12);
        else if (pick < 97)
            size = $urandom_range(30, 40);
        else
            size = $urandom_range(0, 255);
        if (clean || $urandom_range(0, 7) != 0)
            noise_n = clean ? 0 : $urandom_range(0, 4);
        else
            noise_n = $urandom_range(60, 68);
        cmd = (clean || $urandom_range(0, 3) != 0) ? want_cmd : 8'($urandom_range(0, 255));

        send_item(MODE_START, 8'($urandom_range(0, 255)));
        repeat (noise_n)
        begin
            b = 8'($urandom_range(0, 255));
            send_item(MODE_BYTE, (b == CH_DOLLAR) ? ~b : b);
        end
        if (flaw < 6)
        begin
            b = 8'($urandom_range(0, 255));
            send_item(MODE_BYTE, CH_DOLLAR);
            if (flaw < 3)
                send_item(MODE_BYTE, (b == CH_M) ? ~b : b);
            else
            begin
                send_item(MODE_BYTE, CH_M);
                send_item(MODE_BYTE, (b == CH_GT) ? ~b : b);
            end
            return;
        end
        send_preamble();
        send_item(MODE_BYTE, 8'(size));
        send_item(MODE_BYTE, cmd);
        sum = 8'(size) ^ cmd;
        for (int k = 0; k < size; k++)
        begin
            b = 8'($urandom_range(0, 255));
            if (flaw < 10 && k == size / 2)
            begin
                send_item(MODE_TIMEOUT, b);
                return;
            end
            sum = sum ^ b;
            send_item(MODE_BYTE, b);
        end
        if (flaw >= 10 && flaw < 25)
            sum = sum ^ (8'h01 << $urandom_range(0, 7));
        send_item(MODE_BYTE, sum);
    endtask

    initial
    begin : receiver
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
                hold_done = 1'b1;
            end
            else
                out_stall <= !quiet && ($urandom_range(0, 99) < 12);
        end
    end

    initial
    begin : watchdog
        int stuck;
        stuck = 0;
        while (stuck < STUCK_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
                stuck = 0;
            else
                stuck++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin : stimulus
        int goal;
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ignored while idle, including the unused mode
        send_item(MODE_BYTE, 8'hFF);
        send_item(MODE_TIMEOUT, 8'h00);
        send_item(MODE_NONE, 8'h00);
        // timeout during the hunt
        send_item(MODE_START, 8'h00);
        send_item(MODE_TIMEOUT, 8'hFF);
        // bad preamble
        send_item(MODE_START, 8'hA5);
        send_item(MODE_BYTE, CH_DOLLAR);
        send_item(MODE_BYTE, 8'h00);
        // one good channel with reset configuration
        send_item(MODE_START, 8'h5A);
        send_preamble();
        send_item(MODE_BYTE, 8'd2);
        send_item(MODE_BYTE, EXPECTED_COMMAND_RST);
        send_item(MODE_BYTE, 8'h34);
        send_item(MODE_BYTE, 8'h12);
        send_item(MODE_BYTE, 8'd2 ^ EXPECTED_COMMAND_RST ^ 8'h34 ^ 8'h12);
        // zero size, payload too short
        send_item(MODE_START, 8'hFF);
        send_preamble();
        send_item(MODE_BYTE, 8'd0);
        send_item(MODE_BYTE, EXPECTED_COMMAND_RST);
        send_item(MODE_BYTE, EXPECTED_COMMAND_RST);
        settle();

        goal = items_sent;
        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0:
                begin
                    want_cmd = EXPECTED_COMMAND_RST;
                    max_ch = 8'd18;
                end
                1:
                begin
                    want_cmd = 8'd0;
                    max_ch = 8'd0;
                end
                2:
                begin
                    want_cmd = 8'd255;
                    max_ch = 8'd1;
                end
                3:
                begin
                    want_cmd = 8'($urandom_range(0, 255));
                    max_ch = 8'd31;
                end
                4:
                begin
                    want_cmd = 8'($urandom_range(0, 255));
                    max_ch = 8'd17;
                end
                default:
                begin
                    want_cmd = 8'($urandom_range(0, 255));
                    max_ch = 8'($urandom_range(0, 18));
                end
            endcase
            write_reg(REG_EXPECTED_COMMAND, want_cmd);
            write_reg(REG_MAX_CHANNELS, max_ch);
            quiet = (ph == 4);
            if (ph == 3)
            begin
                // receiver holds off while full responses keep coming
                hold_req = 1'b1;
                send_frame(1'b1);
                send_frame(1'b1);
                send_frame(1'b1);
                hold_req = 1'b0;
            end
            goal += ITEMS / PHASES;
            while (items_sent < goal)
            begin
                if ($urandom_range(0, 4) != 0)
                    send_frame(1'b0);
                else
                    send_noise();
            end
            settle();
        end

        if (fail_count == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/mrp_pkg.sv
rtl/mrp_ctrl.sv
rtl/mrp_dp.sv
rtl/msp_v1_rc_response_parser.sv
tb/sv/mrp_frame_checker.sv
tb/sv/testbench.sv
